// ----- rtl/fttbl_pkg.sv -----
package fttbl_pkg;

  localparam int unsigned TableDepthDefault = 1024;

  localparam logic [7:0]  TcpProto = 8'd6;
  localparam logic [7:0]  FlagFin  = 8'h01;
  localparam logic [7:0]  FlagSyn  = 8'h02;
  localparam logic [7:0]  FlagRst  = 8'h04;
  localparam logic [7:0]  FlagAck  = 8'h10;
  localparam logic [29:0] NsPerSec = 30'd1000000000;

  localparam logic [10:0] FlowLimitReset = 11'd1024;
  localparam logic [31:0] TimeoutReset   = 32'd60;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_SWEEP  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_FLOW_LIMIT = 2'd0,
    CFG_TIMEOUT    = 2'd1,
    CFG_SPARE_A    = 2'd2,
    CFG_SPARE_B    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] src_address;
    logic [31:0] dst_address;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  protocol;
    logic [63:0] time_ns;
    logic [15:0] length;
    logic        fwd_dir;
    logic [7:0]  flag_bits;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [10:0] removed_count;
    logic [47:0] bytes_out;
    logic [47:0] bytes_in;
    logic [31:0] packets_out;
    logic [31:0] packets_in;
    logic [7:0]  flags_seen;
    logic [15:0] syn_seen;
    logic [15:0] ack_seen;
    logic [15:0] rst_seen;
    logic [15:0] fin_seen;
    logic [1:0]  conn_marks;
  } result_t;

  typedef struct packed {
    logic     valid;
    in_item_t item;
  } q_stat_t;

endpackage

// ----- rtl/fttbl_front.sv -----
module fttbl_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  fttbl_pkg::in_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output fttbl_pkg::q_stat_t  q_o
);
  import fttbl_pkg::*;

  // two-entry command queue
  in_item_t   buf_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o     = (cnt_q == 2'd2);
  assign q_o.valid  = (cnt_q != 2'd0);
  assign q_o.item   = buf_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

// ----- rtl/fttbl_back.sv -----
module fttbl_back #(
  parameter int unsigned TableDepth = fttbl_pkg::TableDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fttbl_pkg::q_stat_t q_i,
  output logic              pop_o,
  input  logic [10:0]       flow_limit_i,
  input  logic [31:0]       timeout_i,
  output logic              clearing_o,
  output logic              idle_o,
  output logic              res_valid_o,
  output fttbl_pkg::result_t res_o
);
  import fttbl_pkg::*;

  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW = IdxW + 1;

  typedef struct packed {
    logic        valid;
    logic [31:0] src_address;
    logic [31:0] dst_address;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  protocol;
    logic [63:0] seen_ns;
    logic [47:0] bytes_out;
    logic [47:0] bytes_in;
    logic [31:0] packets_out;
    logic [31:0] packets_in;
    logic [7:0]  flag_mask;
    logic [15:0] syn_cnt;
    logic [15:0] ack_cnt;
    logic [15:0] rst_cnt;
    logic [15:0] fin_cnt;
    logic        established;
    logic        closed;
  } entry_t;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_EVICT  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_e;

  function automatic logic [15:0] bump16(logic [15:0] c);
    return (c == 16'hFFFF) ? c : c + 16'd1;
  endfunction

  function automatic logic [31:0] bump32(logic [31:0] c);
    return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

  function automatic logic [47:0] add48(logic [47:0] b, logic [15:0] len);
    logic [48:0] s;
    s = {1'b0, b} + {33'd0, len};
    return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
  endfunction

  function automatic entry_t apply_pkt(entry_t e, in_item_t c);
    entry_t r;
    r = e;
    r.seen_ns = c.time_ns;
    if (c.fwd_dir) begin
      r.bytes_out   = add48(e.bytes_out, c.length);
      r.packets_out = bump32(e.packets_out);
    end else begin
      r.bytes_in   = add48(e.bytes_in, c.length);
      r.packets_in = bump32(e.packets_in);
    end
    if (c.protocol == TcpProto) begin
      r.flag_mask = e.flag_mask | c.flag_bits;
      if ((c.flag_bits & FlagSyn) != 8'd0) begin
        r.syn_cnt = bump16(e.syn_cnt);
        if ((c.flag_bits & FlagAck) != 8'd0) r.established = 1'b1;
      end
      if ((c.flag_bits & FlagAck) != 8'd0) r.ack_cnt = bump16(e.ack_cnt);
      if ((c.flag_bits & FlagRst) != 8'd0) begin
        r.rst_cnt = bump16(e.rst_cnt);
        r.closed  = 1'b1;
      end
      if ((c.flag_bits & FlagFin) != 8'd0) begin
        r.fin_cnt = bump16(e.fin_cnt);
        r.closed  = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic result_t stats(entry_t e, logic hit);
    result_t r;
    r.found         = hit;
    r.removed_count = 11'd0;
    r.bytes_out     = e.bytes_out;
    r.bytes_in      = e.bytes_in;
    r.packets_out   = e.packets_out;
    r.packets_in    = e.packets_in;
    r.flags_seen    = e.flag_mask;
    r.syn_seen      = e.syn_cnt;
    r.ack_seen      = e.ack_cnt;
    r.rst_seen      = e.rst_cnt;
    r.fin_seen      = e.fin_cnt;
    r.conn_marks    = {e.closed, e.established};
    return r;
  endfunction

  // table memory, one entry per slot
  entry_t            mem [TableDepth];
  entry_t            rdata_q;
  logic              we;
  logic [IdxW-1:0]   waddr;
  entry_t            wdata;

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q;
  logic              rd_vld_q;
  logic [IdxW-1:0]   rd_idx_q;
  in_item_t          cur_q;
  logic              hit_q, have_free_q, have_old_q;
  logic [IdxW-1:0]   hit_idx_q, free_q, old_q;
  logic [63:0]       old_ts_q;
  entry_t            hit_ent_q;
  logic [CntW-1:0]   removed_q;
  logic [CntW-1:0]   occ_q;
  result_t           res_q, res_d;
  logic              res_valid_q;

  // timeout in ns, built from two 16 x 30 products
  logic [45:0]       tmo_lo_q, tmo_hi_q;
  logic [63:0]       tmo_q;

  always_ff @(posedge clk_i) begin
    tmo_lo_q <= timeout_i[15:0] * NsPerSec;
    tmo_hi_q <= timeout_i[31:16] * NsPerSec;
    tmo_q    <= {2'b00, tmo_hi_q, 16'd0} + {18'd0, tmo_lo_q};
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[cnt_q[IdxW-1:0]];
  end

  // key match and sweep test on the beat read back
  logic rd_match, rd_expired;
  assign rd_match = rdata_q.valid &&
                    rdata_q.src_address == cur_q.src_address &&
                    rdata_q.dst_address == cur_q.dst_address &&
                    rdata_q.sport == cur_q.sport &&
                    rdata_q.dport == cur_q.dport &&
                    rdata_q.protocol == cur_q.protocol;
  assign rd_expired = rdata_q.valid && ((cur_q.time_ns - rdata_q.seen_ns) > tmo_q);

  logic [31:0] lim32, occ32;
  logic        evict_need, late_evict;
  logic [IdxW-1:0] new_slot;
  entry_t      fresh, base, upd;

  always_comb begin
    if (flow_limit_i == 11'd0)                   lim32 = 32'd1;
    else if (32'(flow_limit_i) > TableDepth)     lim32 = TableDepth;
    else                                         lim32 = 32'(flow_limit_i);
    occ32      = 32'(occ_q);
    evict_need = !hit_q && (occ32 >= lim32) && have_old_q;
    new_slot   = (evict_need && (!have_free_q || old_q < free_q)) ? old_q : free_q;
    late_evict = evict_need && have_free_q && (free_q < old_q);

    fresh             = '0;
    fresh.valid       = 1'b1;
    fresh.src_address = cur_q.src_address;
    fresh.dst_address = cur_q.dst_address;
    fresh.sport       = cur_q.sport;
    fresh.dport       = cur_q.dport;
    fresh.protocol    = cur_q.protocol;
    base = hit_q ? hit_ent_q : fresh;
    upd  = apply_pkt(base, cur_q);
  end

  always_comb begin
    res_d = '0;
    case (cur_q.operation)
      OP_UPDATE: res_d = stats(upd, hit_q);
      OP_LOOKUP: if (hit_q) res_d = stats(hit_ent_q, 1'b1);
      OP_SWEEP:  res_d.removed_count = 11'(removed_q);
      default:   ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    we      = 1'b0;
    waddr   = rd_idx_q;
    wdata   = '0;
    case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = cnt_q[IdxW-1:0];
        if (cnt_q == CntW'(TableDepth - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_i.valid) begin
          pop_o   = 1'b1;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_vld_q && cur_q.operation == OP_SWEEP && rd_expired) begin
          we    = 1'b1;
          waddr = rd_idx_q;
          wdata = rdata_q;
          wdata.valid = 1'b0;
        end
        if (cnt_q == CntW'(TableDepth) && !rd_vld_q) begin
          state_d = (cur_q.operation == OP_UPDATE && late_evict) ? ST_EVICT : ST_FINISH;
        end
      end
      ST_EVICT: begin
        we      = 1'b1;
        waddr   = old_q;
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (cur_q.operation == OP_UPDATE) begin
          we    = 1'b1;
          waddr = hit_q ? hit_idx_q : new_slot;
          wdata = upd;
        end
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      occ_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= 1'b0;
      rd_vld_q    <= 1'b0;
      case (state_q)
        ST_CLEAR: begin
          cnt_q <= (cnt_q == CntW'(TableDepth - 1)) ? '0 : cnt_q + 1'b1;
        end
        ST_IDLE: begin
          cnt_q <= '0;
        end
        ST_SCAN: begin
          if (cnt_q != CntW'(TableDepth)) begin
            rd_vld_q <= 1'b1;
            cnt_q    <= cnt_q + 1'b1;
          end
        end
        ST_FINISH: begin
          res_valid_q <= 1'b1;
          if (cur_q.operation == OP_UPDATE && !hit_q && !evict_need) begin
            occ_q <= occ_q + 1'b1;
          end else if (cur_q.operation == OP_SWEEP) begin
            occ_q <= occ_q - removed_q;
          end
        end
        default: ;
      endcase
    end
  end

  // scan bookkeeping and result, payload only
  always_ff @(posedge clk_i) begin
    rd_idx_q <= cnt_q[IdxW-1:0];
    if (state_q == ST_IDLE && q_i.valid) begin
      cur_q       <= q_i.item;
      hit_q       <= 1'b0;
      have_free_q <= 1'b0;
      have_old_q  <= 1'b0;
      removed_q   <= '0;
    end
    if (state_q == ST_SCAN && rd_vld_q) begin
      if (rd_match && !hit_q) begin
        hit_q     <= 1'b1;
        hit_idx_q <= rd_idx_q;
        hit_ent_q <= rdata_q;
      end
      if (!rdata_q.valid && !have_free_q) begin
        have_free_q <= 1'b1;
        free_q      <= rd_idx_q;
      end
      if (rdata_q.valid && (!have_old_q || rdata_q.seen_ns < old_ts_q)) begin
        have_old_q <= 1'b1;
        old_q      <= rd_idx_q;
        old_ts_q   <= rdata_q.seen_ns;
      end
      if (cur_q.operation == OP_SWEEP && rd_expired) removed_q <= removed_q + 1'b1;
    end
    if (state_q == ST_FINISH) begin
      res_q <= res_d;
    end
  end

  assign clearing_o  = (state_q == ST_CLEAR);
  assign idle_o      = (state_q == ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ----- rtl/five_tuple_flow_table_top.sv -----
// sequence per item: pop in idle, scan of every slot, an eviction write when the evicted slot
// lies above the free slot the new flow takes, then the update write and the result strobe
// the back end takes no new item until the last one is through; every item scans
// the whole table one slot per cycle through the memory read port; up to two commands queue
// reset: a clearing pass over every slot runs first, busy stays high meanwhile
// the result strobe lasts one cycle and the receiver cannot stall it
module five_tuple_flow_table_top #(
  parameter int unsigned TableDepth = fttbl_pkg::TableDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // command beat
  input  logic                start,
  output logic                busy,
  input  fttbl_pkg::in_item_t cmd_i,
  // result beat
  output logic                result_valid_o,
  output fttbl_pkg::result_t  result_o,
  // register writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);
  import fttbl_pkg::*;

  logic        full, clearing, idle, pop, accept;
  q_stat_t     q_stat;
  logic [10:0] flow_limit_q;
  logic [31:0] timeout_q;

  // front queue fills while the back end scans
  assign busy   = full || clearing;
  assign accept = start && !busy;

  // register writes taken only while no command is queued, scanned or being accepted
  assign cfg_ready_o = idle && !q_stat.valid && !accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flow_limit_q <= FlowLimitReset;
      timeout_q    <= TimeoutReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_FLOW_LIMIT: flow_limit_q <= cfg_data_i[10:0];
        CFG_TIMEOUT:    timeout_q    <= cfg_data_i;
        default:        ;
      endcase
    end
  end

  fttbl_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .item_i (cmd_i),
    .full_o (full),
    .pop_i  (pop),
    .q_o    (q_stat)
  );

  // back end: table scan, eviction choice, counter update
  fttbl_back #(
    .TableDepth (TableDepth)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_i          (q_stat),
    .pop_o        (pop),
    .flow_limit_i (flow_limit_q),
    .timeout_i    (timeout_q),
    .clearing_o   (clearing),
    .idle_o       (idle),
    .res_valid_o  (result_valid_o),
    .res_o        (result_o)
  );

endmodule

// ----- tb/flow_table_checker.sv -----
module flow_table_checker
  import fttbl_pkg::*;
#(
  parameter int unsigned Depth = TableDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  in_item_t    cmd_i,
  input  logic        result_valid_i,
  input  result_t     result_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow of the flow table
  bit          slot_used[Depth];
  bit [63:0]   slot_addr[Depth];
  bit [39:0]   slot_pp[Depth];
  bit [63:0]   slot_last[Depth];
  bit [47:0]   slot_bytes[2*Depth];
  bit [31:0]   slot_pkts[2*Depth];
  bit [15:0]   slot_syn[Depth];
  bit [15:0]   slot_ack[Depth];
  bit [15:0]   slot_rst[Depth];
  bit [15:0]   slot_fin[Depth];
  bit [7:0]    slot_mask[Depth];
  bit [1:0]    slot_marks[Depth];
  int          live_flows;
  bit [10:0]   flow_limit_q;
  bit [31:0]   timeout_q;

  result_t     expected_stats_q[$];

  function automatic bit [15:0] sat_inc16(bit [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic int slot_of(bit [63:0] addr, bit [39:0] pp);
    for (int i = 0; i < Depth; i++)
      if (slot_used[i] && slot_addr[i] == addr && slot_pp[i] == pp) return i;
    return -1;
  endfunction

  function automatic void fill_stats(int s, ref result_t r);
    r.bytes_out   = slot_bytes[2*s];
    r.bytes_in    = slot_bytes[2*s+1];
    r.packets_out = slot_pkts[2*s];
    r.packets_in  = slot_pkts[2*s+1];
    r.flags_seen  = slot_mask[s];
    r.syn_seen    = slot_syn[s];
    r.ack_seen    = slot_ack[s];
    r.rst_seen    = slot_rst[s];
    r.fin_seen    = slot_fin[s];
    r.conn_marks  = slot_marks[s];
  endfunction

  function automatic result_t flow_stats_after(in_item_t it);
    result_t   r;
    bit [63:0] addr;
    bit [39:0] pp;
    bit [63:0] tmo;
    int        s;
    int        oldest;
    int        lim;
    int        d;
    int        removed;
    r = '0;
    addr = {it.src_address, it.dst_address};
    pp = {it.sport, it.dport, it.protocol};
    case (op_e'(it.operation))
      OP_UPDATE: begin
        lim = (flow_limit_q == 0) ? 1 : ((flow_limit_q > Depth) ? Depth : flow_limit_q);
        s = slot_of(addr, pp);
        if (s >= 0) begin
          r.found = 1'b1;
        end else begin
          // full table: evict least recently seen, lowest slot on a tie
          if (live_flows >= lim) begin
            oldest = -1;
            for (int i = 0; i < Depth; i++)
              if (slot_used[i] && (oldest < 0 || slot_last[i] < slot_last[oldest]))
                oldest = i;
            if (oldest >= 0) begin
              slot_used[oldest] = 1'b0;
              live_flows--;
            end
          end
          s = 0;
          while (s < Depth && slot_used[s]) s++;
          slot_used[s] = 1'b1;
          live_flows++;
          slot_addr[s] = addr;
          slot_pp[s] = pp;
          slot_bytes[2*s] = '0;
          slot_bytes[2*s+1] = '0;
          slot_pkts[2*s] = '0;
          slot_pkts[2*s+1] = '0;
          slot_syn[s] = '0;
          slot_ack[s] = '0;
          slot_rst[s] = '0;
          slot_fin[s] = '0;
          slot_mask[s] = '0;
          slot_marks[s] = '0;
        end
        slot_last[s] = it.time_ns;
        d = 2*s + (it.fwd_dir ? 0 : 1);
        slot_bytes[d] = (48'hFFFF_FFFF_FFFF - slot_bytes[d] < it.length) ?
                        48'hFFFF_FFFF_FFFF : slot_bytes[d] + it.length;
        if (slot_pkts[d] != 32'hFFFF_FFFF) slot_pkts[d]++;
        if (it.protocol == TcpProto) begin
          slot_mask[s] |= it.flag_bits;
          if (it.flag_bits & FlagSyn) begin
            slot_syn[s] = sat_inc16(slot_syn[s]);
            if (it.flag_bits & FlagAck) slot_marks[s][0] = 1'b1;
          end
          if (it.flag_bits & FlagAck) slot_ack[s] = sat_inc16(slot_ack[s]);
          if (it.flag_bits & FlagRst) begin
            slot_rst[s] = sat_inc16(slot_rst[s]);
            slot_marks[s][1] = 1'b1;
          end
          if (it.flag_bits & FlagFin) begin
            slot_fin[s] = sat_inc16(slot_fin[s]);
            slot_marks[s][1] = 1'b1;
          end
        end
        fill_stats(s, r);
      end
      OP_LOOKUP: begin
        s = slot_of(addr, pp);
        if (s >= 0) begin
          r.found = 1'b1;
          fill_stats(s, r);
        end
      end
      OP_SWEEP: begin
        tmo = 64'(timeout_q) * 64'(NsPerSec);
        removed = 0;
        for (int i = 0; i < Depth; i++)
          if (slot_used[i] && (it.time_ns - slot_last[i]) > tmo) begin
            slot_used[i] = 1'b0;
            removed++;
          end
        live_flows -= removed;
        r.removed_count = removed[10:0];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t e;
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) slot_used[i] = 1'b0;
      live_flows = 0;
      flow_limit_q = FlowLimitReset;
      timeout_q = TimeoutReset;
      expected_stats_q.delete();
    end else begin
      if (result_valid_i) begin
        if (expected_stats_q.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count_o++;
        end else begin
          e = expected_stats_q.pop_front();
          check_field("found", e.found, result_i.found);
          check_field("removed_count", e.removed_count, result_i.removed_count);
          check_field("bytes_out", e.bytes_out, result_i.bytes_out);
          check_field("bytes_in", e.bytes_in, result_i.bytes_in);
          check_field("packets_out", e.packets_out, result_i.packets_out);
          check_field("packets_in", e.packets_in, result_i.packets_in);
          check_field("flags_seen", e.flags_seen, result_i.flags_seen);
          check_field("syn_seen", e.syn_seen, result_i.syn_seen);
          check_field("ack_seen", e.ack_seen, result_i.ack_seen);
          check_field("rst_seen", e.rst_seen, result_i.rst_seen);
          check_field("fin_seen", e.fin_seen, result_i.fin_seen);
          check_field("conn_marks", e.conn_marks, result_i.conn_marks);
        end
      end
      if (start_i && !busy_i) begin
        expected_stats_q.insert(expected_stats_q.size(), flow_stats_after(cmd_i));
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_FLOW_LIMIT: flow_limit_q = cfg_data_i[10:0];
          CFG_TIMEOUT:    timeout_q = cfg_data_i;
          default: ;
        endcase
      end
    end
    pending_o = expected_stats_q.size();
  end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  import fttbl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = TableDepthDefault;
  // every item scans the whole table, so each beat waits out a full scan
  localparam int Latency = Depth + 20;
  localparam int CycleLimit = 3_000_000;
  localparam int NumKeys = 16;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    cmd;
  logic        result_valid;
  result_t     result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  int          fail_count;
  int          pending;
  int          cycles;

  // small key pool so that updates hit existing flows and evictions happen
  bit [31:0] key_src[NumKeys];
  bit [31:0] key_dst[NumKeys];
  bit [15:0] key_sp[NumKeys];
  bit [15:0] key_dp[NumKeys];
  bit [7:0]  key_proto[NumKeys];
  bit [63:0] now_ns;
  int        burst_left;

  five_tuple_flow_table_top #(.TableDepth(Depth)) u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd),
    .result_valid_o (result_valid),
    .result_o       (result),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  flow_table_checker #(.Depth(Depth)) u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_i         (busy),
    .cmd_i          (cmd),
    .result_valid_i (result_valid),
    .result_i       (result),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: covers the clearing pass, every item's full scan and the gaps
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // one command beat; start stays high into the next beat while a burst lasts
  task automatic send_cmd(in_item_t it);
    cmd <= it;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      // occasional long bursts give stretches with no idling at all
      repeat ($urandom_range(1, 25)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) :
                   $urandom_range(0, 6);
    end
  endtask

  // drop start if a burst left it high, then wait out every expected beat
  task automatic drain();
    if (start) begin
      start <= 1'b0;
      @(posedge clk);
    end
    while (pending != 0) @(posedge clk);
    repeat (Latency) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, bit [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_item_t make_item(op_e op, int k, bit [7:0] flags,
                                         bit [15:0] len, bit fwd);
    in_item_t it;
    it = '0;
    it.operation   = op;
    it.src_address = key_src[k];
    it.dst_address = key_dst[k];
    it.sport       = key_sp[k];
    it.dport       = key_dp[k];
    it.protocol    = key_proto[k];
    it.time_ns     = now_ns;
    it.length      = len;
    it.fwd_dir     = fwd;
    it.flag_bits   = flags;
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    // time mostly moves forward by under a second, at times by many seconds, now and then jumps anywhere
    pick = $urandom_range(0, 39);
    if (pick == 0) now_ns = {$urandom, $urandom};
    else if (pick < 10) now_ns += 64'($urandom) * 4;
    else now_ns += 64'($urandom_range(0, 100_000_000));
    pick = $urandom_range(0, 99);
    it = make_item(pick < 60 ? OP_UPDATE : pick < 82 ? OP_LOOKUP :
                   pick < 95 ? OP_SWEEP : OP_NONE,
                   $urandom_range(0, NumKeys-1), 8'($urandom), 16'($urandom),
                   1'($urandom));
    // a few keys outside the pool for misses and fresh flows
    if ($urandom_range(0, 15) == 0) begin
      it.src_address = $urandom;
      it.dst_address = $urandom;
      it.sport       = 16'($urandom);
      it.dport       = 16'($urandom);
      it.protocol    = 8'($urandom);
    end
    return it;
  endfunction

  task automatic random_phase(int count);
    for (int n = 0; n < count; n++) send_cmd(random_item());
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    cmd = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_FLOW_LIMIT;
    cfg_data = '0;
    burst_left = 0;
    now_ns = 64'd1_000;
    for (int k = 0; k < NumKeys; k++) begin
      key_src[k]   = $urandom;
      key_dst[k]   = $urandom;
      key_sp[k]    = 16'($urandom);
      key_dp[k]    = 16'($urandom);
      key_proto[k] = (k % 3 == 2) ? 8'($urandom) : (k % 3 == 1 ? 8'd17 : TcpProto);
    end
    // extreme keys: addresses and ports all zeros and all ones
    key_src[0] = '0; key_dst[0] = '0; key_sp[0] = '0; key_dp[0] = '0;
    key_src[1] = '1; key_dst[1] = '1; key_sp[1] = '1; key_dp[1] = '1;
    key_proto[0] = TcpProto;
    key_proto[1] = 8'hFF;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: tcp handshake and teardown on one flow
    send_cmd(make_item(OP_UPDATE, 0, FlagSyn, 16'd0, 1'b1));
    send_cmd(make_item(OP_UPDATE, 0, FlagSyn | FlagAck, 16'd60, 1'b0));
    send_cmd(make_item(OP_UPDATE, 0, FlagAck, 16'hFFFF, 1'b1));
    send_cmd(make_item(OP_UPDATE, 0, FlagFin, 16'd40, 1'b0));
    send_cmd(make_item(OP_UPDATE, 0, FlagRst, 16'd40, 1'b1));
    send_cmd(make_item(OP_UPDATE, 0, 8'hFF, 16'hFFFF, 1'b1));
    // non-tcp flags are ignored
    send_cmd(make_item(OP_UPDATE, 1, 8'hFF, 16'hFFFF, 1'b0));
    send_cmd(make_item(OP_UPDATE, 2, 8'h12, 16'd1, 1'b1));
    send_cmd(make_item(OP_LOOKUP, 0, 8'h00, 16'd0, 1'b0));
    send_cmd(make_item(OP_LOOKUP, 1, 8'hFF, 16'hFFFF, 1'b1));
    send_cmd(make_item(OP_LOOKUP, 5, 8'h00, 16'd0, 1'b0));   // miss
    send_cmd(make_item(OP_NONE, 0, 8'hFF, 16'hFFFF, 1'b1));  // unused op
    send_cmd(make_item(OP_SWEEP, 0, 8'h00, 16'd0, 1'b0));    // nothing old yet
    // time far ahead, then back to zero: wrapped age removes the older flows, the two new ones stay
    now_ns = 64'hFFFF_FFFF_FFFF_FFFF;
    send_cmd(make_item(OP_UPDATE, 3, FlagSyn, 16'd100, 1'b1));
    now_ns = 64'd0;
    send_cmd(make_item(OP_UPDATE, 4, FlagAck, 16'd100, 1'b0));
    send_cmd(make_item(OP_SWEEP, 0, 8'h00, 16'd0, 1'b0));
    send_cmd(make_item(OP_LOOKUP, 3, 8'h00, 16'd0, 1'b0));
    now_ns = 64'd5_000_000_000;

    // pause until every expected beat is back, then walk the register settings
    drain();
    write_reg(CFG_TIMEOUT, 32'd0);
    random_phase(40);
    drain();
    write_reg(CFG_FLOW_LIMIT, 32'd1);
    write_reg(CFG_TIMEOUT, 32'd1);
    random_phase(60);
    drain();
    write_reg(CFG_FLOW_LIMIT, 32'd0);           // acts as one
    write_reg(CFG_TIMEOUT, 32'hFFFF_FFFF);
    random_phase(40);
    drain();
    write_reg(CFG_FLOW_LIMIT, 32'd8);
    write_reg(CFG_TIMEOUT, 32'd2);
    random_phase(80);
    drain();
    // limit dropped below occupancy: one eviction per new flow
    write_reg(CFG_FLOW_LIMIT, 32'd3);
    random_phase(60);
    drain();
    write_reg(CFG_FLOW_LIMIT, 32'hFFFF_F7FF);   // low bits 2047, clamps to depth
    write_reg(CFG_TIMEOUT, 32'd60);
    random_phase(70);
    drain();
    write_reg(CFG_FLOW_LIMIT, 32'd1024);
    write_reg(CFG_TIMEOUT, 32'd3);
    random_phase(80);
    drain();

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- five_tuple_flow_table_top.f -----
rtl/fttbl_pkg.sv
rtl/fttbl_front.sv
rtl/fttbl_back.sv
rtl/five_tuple_flow_table_top.sv
tb/flow_table_checker.sv
tb/tb_top.sv
